// ===== rtl/wsf_pkg.sv =====
// ----------------------------------------------------------------------------
// wsf_pkg - shared types and constants of the wind smear pixel filter
// Pixel request and result types, queue entry type, configuration register
// indexes and the fixed coefficients of the luma and blend arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

package wsf_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W           = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOW_FROM_RIGHT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STORM_MODE      = 1'd1;

    // Luma coefficients, result scaled by 2^12
    localparam logic [9:0]  LUMA_COEF_R = 10'd872;
    localparam logic [11:0] LUMA_COEF_G = 12'd2930;
    localparam logic [8:0]  LUMA_COEF_B = 9'd296;
    localparam int unsigned LUMA_SHIFT  = 12;

    // Run counter and blend weight
    localparam int unsigned CNT_W        = 7;
    localparam logic [CNT_W-1:0] WIND_START   = 7'd95;
    localparam logic [CNT_W-1:0] STORM_START  = 7'd105;
    localparam logic [CNT_W-1:0] STORM_WEIGHT = 7'd105;
    localparam logic [7:0]       BLEND_ONE    = 8'd128;
    localparam int unsigned      BLEND_SHIFT  = 7;

    typedef struct packed {
        logic [7:0] pixel_red;
        logic [7:0] pixel_green;
        logic [7:0] pixel_blue;
        logic [4:0] damping_step;
        logic       row_last;
    } t_pixel_in;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       out_row_last;
    } t_pixel_out;

    typedef struct packed {
        t_pixel_in  pixel;
        logic [7:0] luma;
    } t_queue_item;

    typedef struct packed {
        logic blow_from_right;
        logic storm_mode;
    } t_cfg;

endpackage

`default_nettype wire

// ===== rtl/wsf_front.sv =====
// ----------------------------------------------------------------------------
// wsf_front - request intake and luma classification
// Registers each accepted pixel together with its luma and offers it to
// the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module wsf_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_stall,
    input  wsf_pkg::t_pixel_in   i_pixel,
    output logic                 o_push,
    input  wire                  i_full,
    output wsf_pkg::t_queue_item o_item
);

    logic                 r_valid;
    logic                 n_valid;
    wsf_pkg::t_queue_item r_item;
    logic                 take;
    logic [19:0]          luma_sum;

    always_comb begin
        luma_sum = 20'(i_pixel.pixel_red   * wsf_pkg::LUMA_COEF_R)
                 + 20'(i_pixel.pixel_green * wsf_pkg::LUMA_COEF_G)
                 + 20'(i_pixel.pixel_blue  * wsf_pkg::LUMA_COEF_B);
    end

    assign o_stall = r_valid & i_full;
    assign take    = i_valid & ~o_stall;
    assign o_push  = r_valid & ~i_full;
    assign o_item  = r_item;
    assign n_valid = take | (r_valid & i_full);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Hold the payload while the queue is full
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item.pixel <= i_pixel;
            r_item.luma  <= luma_sum[wsf_pkg::LUMA_SHIFT +: 8];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/wsf_queue.sv =====
// ----------------------------------------------------------------------------
// wsf_queue - short request queue between front and back
// Register-based first-in first-out store with a fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module wsf_queue #(
    parameter int unsigned P_DEPTH = 4
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  wsf_pkg::t_queue_item i_item,
    output logic                 o_full,
    input  wire                  i_pop,
    output logic                 o_empty,
    output wsf_pkg::t_queue_item o_item
);

    localparam int unsigned PTR_W = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(P_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(P_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(P_DEPTH);

    wsf_pkg::t_queue_item r_mem [P_DEPTH];
    logic [PTR_W-1:0]     r_wr_ptr;
    logic [PTR_W-1:0]     r_rd_ptr;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/wsf_back.sv =====
// ----------------------------------------------------------------------------
// wsf_back - smear recurrence and result register
// Tracks the held source pixel and run counter, blends darker followers
// toward the source and registers each result for the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module wsf_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wsf_pkg::t_cfg        i_cfg,
    input  wire                  i_empty,
    input  wsf_pkg::t_queue_item i_item,
    output logic                 o_pop,
    output logic                 o_valid,
    input  wire                  i_stall,
    output wsf_pkg::t_pixel_out  o_pixel
);

    localparam int unsigned CW = wsf_pkg::CNT_W;

    logic                r_out_valid;
    wsf_pkg::t_pixel_out r_out;
    logic                r_phase;
    logic [23:0]         r_held_color;
    logic [7:0]          r_held_luma;
    logic [CW-1:0]       r_run_counter;
    logic [4:0]          r_run_damping;

    wsf_pkg::t_pixel_in  pix;
    logic                blend;
    logic [CW-1:0]       weight;
    logic [7:0]          weight_inv;
    logic [CW-1:0]       start_val;
    wsf_pkg::t_pixel_out result;

    function automatic logic [CW-1:0] counter_drop(input logic [CW-1:0] c,
                                                   input logic [4:0] d);
        logic [CW-1:0] dw;
        dw = CW'(d);
        return (dw >= c) ? '0 : c - dw;
    endfunction

    function automatic logic [7:0] mix(input logic [7:0] src, input logic [7:0] cur,
                                       input logic [CW-1:0] w, input logic [7:0] w_inv);
        logic [15:0] acc;
        acc = 16'(src * w) + 16'(cur * w_inv);
        return acc[wsf_pkg::BLEND_SHIFT +: 8];
    endfunction

    assign pix     = i_item.pixel;
    assign o_pop   = ~i_empty & (~r_out_valid | ~i_stall);
    assign o_valid = r_out_valid;
    assign o_pixel = r_out;

    always_comb begin
        blend = r_phase & ~pix.row_last & (i_item.luma < r_held_luma)
              & (r_run_counter != '0);
        weight     = i_cfg.storm_mode ? wsf_pkg::STORM_WEIGHT : r_run_counter;
        weight_inv = wsf_pkg::BLEND_ONE - 8'(weight);
        start_val  = i_cfg.storm_mode ? wsf_pkg::STORM_START : wsf_pkg::WIND_START;

        result.out_red      = pix.pixel_red;
        result.out_green    = pix.pixel_green;
        result.out_blue     = pix.pixel_blue;
        result.out_row_last = pix.row_last;
        if (blend) begin
            result.out_red   = mix(r_held_color[23:16], pix.pixel_red,   weight, weight_inv);
            result.out_green = mix(r_held_color[15:8],  pix.pixel_green, weight, weight_inv);
            result.out_blue  = mix(r_held_color[7:0],   pix.pixel_blue,  weight, weight_inv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_phase       <= 1'b0;
            r_held_color  <= '0;
            r_held_luma   <= '0;
            r_run_counter <= '0;
            r_run_damping <= '0;
        end else begin
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                priority if (pix.row_last) begin
                    r_phase <= 1'b0;
                end else if (blend) begin
                    r_run_counter <= counter_drop(r_run_counter, r_run_damping);
                end else begin
                    r_phase       <= 1'b1;
                    r_held_color  <= {pix.pixel_red, pix.pixel_green, pix.pixel_blue};
                    r_held_luma   <= i_item.luma;
                    r_run_damping <= pix.damping_step;
                    r_run_counter <= i_cfg.blow_from_right
                                   ? counter_drop(start_val, pix.damping_step) : start_val;
                end
            end
        end
    end

    // Hold the result while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= result;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/wind_smear_pixel_filter.sv =====
// ----------------------------------------------------------------------------
// wind_smear_pixel_filter - wind / storm smear effect on a pixel stream
//
// Feed the RGB pixels of one row in order on the input channel (i_valid /
// o_stall, payload i_pixel), with row_last set on the final pixel of each
// row. Every pixel yields exactly one result on the output channel (o_valid /
// i_stall, payload o_pixel), in order. A request moves when valid is high
// and stall is low. For right-to-left wind, feed the row reversed and set
// blow_from_right.
// Configuration goes through the write channel i_cfg_valid / o_cfg_ready,
// which is always ready; write registers only while the filter is idle.
// Path: a request accepted into the intake register is written to the
// queue, then popped into the result register, where it is offered.
// Throughput: one pixel per cycle while the receiver does not stall; the
// limit is the source/counter recurrence in the back end.
// A stalled receiver fills the result register, then the queue
// (P_QUEUE_DEPTH entries), then the intake register, after which o_stall
// rises; nothing is dropped.
// Reset (synchronous, active low) empties every stage, clears the held
// source and run counter, and sets both registers to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module wind_smear_pixel_filter #(
    parameter int unsigned P_QUEUE_DEPTH = 4
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_valid,
    output logic                             o_stall,
    input  wsf_pkg::t_pixel_in               i_pixel,
    output logic                             o_valid,
    input  wire                              i_stall,
    output wsf_pkg::t_pixel_out              o_pixel,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [wsf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [0:0]                       i_cfg_data
);

    wsf_pkg::t_cfg        r_cfg;
    wsf_pkg::t_queue_item front_item;
    wsf_pkg::t_queue_item queue_item;
    logic                 push;
    logic                 queue_full;
    logic                 queue_empty;
    logic                 pop;

    // Configuration writes are always accepted and registered in r_cfg
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                wsf_pkg::CFG_BLOW_FROM_RIGHT: r_cfg.blow_from_right <= i_cfg_data[0];
                wsf_pkg::CFG_STORM_MODE:      r_cfg.storm_mode      <= i_cfg_data[0];
                default:                      r_cfg                 <= r_cfg;
            endcase
        end
    end

    // Front: register the request and its luma
    wsf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_pixel (i_pixel),
        .o_push  (push),
        .i_full  (queue_full),
        .o_item  (front_item)
    );

    // Queue: decouple intake from the smear recurrence
    wsf_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_empty (queue_empty),
        .o_item  (queue_item)
    );

    // Back: advance the source/run state and register the result
    wsf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_empty (queue_empty),
        .i_item  (queue_item),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_pixel (o_pixel)
    );

endmodule

`default_nettype wire

// ===== rtl/wsf_checker.sv =====
// ----------------------------------------------------------------------------
// wsf_checker - port-level checks of the wind smear pixel filter
// Tracks requests in flight from the ports and checks the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module wsf_checker #(
    parameter int unsigned P_QUEUE_DEPTH = 4
) (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_valid,
    input wire                 o_stall,
    input wire                 o_valid,
    input wire                 i_stall,
    input wsf_pkg::t_pixel_out o_pixel
);

    localparam int unsigned CNT_W = $clog2(P_QUEUE_DEPTH + 3);

    logic [CNT_W-1:0] r_inflight;
    logic             in_take;
    logic             out_take;

    assign in_take  = i_valid & ~o_stall;
    assign out_take = o_valid & ~i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + CNT_W'(in_take) - CNT_W'(out_take);
        end
    end

    // Nothing offered in the cycle after reset
    a_reset_idle: assert property (@(posedge i_clk)
        (i_rst_n && !$past(i_rst_n)) |-> !o_valid)
        else $error("result offered right after reset");

    // No result without an accepted request behind it
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_inflight != '0))
        else $error("result with no request in flight");

    // Empty filter never pushes back
    a_empty_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_inflight == '0) |-> !o_stall)
        else $error("intake stalled while empty");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_pixel)))
        else $error("stalled result changed");

endmodule

bind wind_smear_pixel_filter wsf_checker #(
    .P_QUEUE_DEPTH (P_QUEUE_DEPTH)
) u_wsf_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_pixel (o_pixel)
);

`default_nettype wire

// ===== sim/wind_smear_pixel_filter_test.sv =====
// ----------------------------------------------------------------------------
// wind_smear_pixel_filter_test - self-checking bench of the wind smear filter
// Feeds rows of pixels through the filter, from hand-picked cases and then
// random rows, under each register setting, with random idle on the sender
// and random stall on the receiver. Every accepted request is run through
// a bench copy of the smear arithmetic, and each result is checked, field by
// field and in order, against the pixel that the copy produced.
// ----------------------------------------------------------------------------

module wind_smear_pixel_filter_test;
    import wsf_pkg::*;

    localparam int unsigned RESET_CYCLES = 12;
    localparam int unsigned MAX_WAIT     = 12;    // longest idle or stall per request
    localparam int unsigned PHASES       = 8;
    localparam int unsigned PHASE_ITEMS  = 200;   // random pixels per register setting
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned MAX_REPORTS  = 200;   // keep the log short on a broken build

    // ------------------------------------------------------------------------
    // Block ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic                 o_stall;
    t_pixel_in            i_pixel     = '0;
    logic                 o_valid;
    logic                 i_stall     = 1'b0;
    t_pixel_out           o_pixel;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_BLOW_FROM_RIGHT;
    logic [0:0]           i_cfg_data  = 1'b0;

    wind_smear_pixel_filter i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_pixel     (i_pixel),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_pixel     (o_pixel),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin : clock_gen
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Bench copy of the filter: registers and the held smear source
    // ------------------------------------------------------------------------
    logic       blow_right_reg = 1'b0;
    logic       storm_reg      = 1'b0;
    logic       source_held    = 1'b0;
    logic [7:0] source_red     = '0;
    logic [7:0] source_green   = '0;
    logic [7:0] source_blue    = '0;
    logic [7:0] source_luma    = '0;
    logic [7:0] run_count      = '0;
    logic [4:0] run_step       = '0;

    t_pixel_in   pixel_backlog[$];     // pixels waiting to be offered
    t_pixel_out  smeared_expected[$];  // predicted results, oldest first

    int unsigned queued_count   = 0;
    int unsigned checked_count  = 0;
    int unsigned mismatch_count = 0;
    int unsigned send_idle      = 0;
    int unsigned recv_idle      = 0;
    bit          send_burst     = 1'b0;
    bit          recv_burst     = 1'b0;

    // Lower the run counter, saturating at zero
    function automatic logic [7:0] lower_count(logic [7:0] count, logic [4:0] step);
        return (step >= count) ? 8'd0 : count - step;
    endfunction

    function automatic logic [7:0] blend_toward(logic [7:0] src, logic [7:0] cur,
                                                int unsigned weight);
        int unsigned acc;
        acc = src * weight + cur * (BLEND_ONE - weight);
        return 8'(acc >> BLEND_SHIFT);
    endfunction

    // Advance the bench copy by one pixel and return the pixel it emits
    function automatic t_pixel_out smear_pixel(t_pixel_in px);
        int unsigned luma_sum;
        logic [7:0]  luma;
        int unsigned weight;
        logic [7:0]  start_count;
        t_pixel_out  res;
        luma_sum = px.pixel_red * LUMA_COEF_R + px.pixel_green * LUMA_COEF_G
                 + px.pixel_blue * LUMA_COEF_B;
        luma = 8'(luma_sum >> LUMA_SHIFT);
        res.out_red      = px.pixel_red;
        res.out_green    = px.pixel_green;
        res.out_blue     = px.pixel_blue;
        res.out_row_last = px.row_last;
        if (source_held && !px.row_last && luma < source_luma && run_count != 0) begin
            // darker pixel inside a live run: pull it toward the source
            weight = storm_reg ? int'(STORM_WEIGHT) : int'(run_count);
            res.out_red   = blend_toward(source_red, px.pixel_red, weight);
            res.out_green = blend_toward(source_green, px.pixel_green, weight);
            res.out_blue  = blend_toward(source_blue, px.pixel_blue, weight);
            run_count = lower_count(run_count, run_step);
        end else if (!px.row_last) begin
            // unchanged pixel becomes the new source
            start_count  = 8'(storm_reg ? STORM_START : WIND_START);
            source_held  = 1'b1;
            source_red   = px.pixel_red;
            source_green = px.pixel_green;
            source_blue  = px.pixel_blue;
            source_luma  = luma;
            run_step     = px.damping_step;
            run_count    = blow_right_reg ? lower_count(start_count, px.damping_step)
                                          : start_count;
        end
        // end of row drops the source
        if (px.row_last) source_held = 1'b0;
        return res;
    endfunction

    function automatic int unsigned draw_wait(bit burst);
        return burst ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        if (mismatch_count < MAX_REPORTS)
            $display("mismatch at result %0d: %s got %0d expected %0d",
                     checked_count, what, got, want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Driver: offer backlog pixels, idle a random count after each request
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                // request taken: predict its result and draw the next gap
                smeared_expected.push_back(smear_pixel(i_pixel));
                if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
                send_idle = draw_wait(send_burst);
            end
            // hold a stalled request; otherwise pick the next one or idle
            if (!i_valid || !o_stall) begin
                if (send_idle != 0) begin
                    send_idle--;
                    i_valid <= 1'b0;
                end else if (pixel_backlog.size() != 0) begin
                    i_pixel <= pixel_backlog.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each result, stall a random count after each one
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        t_pixel_out want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                checked_count++;
                if (smeared_expected.size() == 0) begin
                    report_mismatch("result with no request pending", o_pixel, 0);
                end else begin
                    want = smeared_expected.pop_front();
                    if (o_pixel.out_red !== want.out_red)
                        report_mismatch("out_red", o_pixel.out_red, want.out_red);
                    if (o_pixel.out_green !== want.out_green)
                        report_mismatch("out_green", o_pixel.out_green, want.out_green);
                    if (o_pixel.out_blue !== want.out_blue)
                        report_mismatch("out_blue", o_pixel.out_blue, want.out_blue);
                    if (o_pixel.out_row_last !== want.out_row_last)
                        report_mismatch("out_row_last", o_pixel.out_row_last,
                                        want.out_row_last);
                end
                if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
                recv_idle = draw_wait(recv_burst);
            end
            if (recv_idle != 0) begin
                recv_idle--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic write_register(logic [CFG_IDX_W-1:0] index, logic value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (index)
            CFG_BLOW_FROM_RIGHT: blow_right_reg = value;
            CFG_STORM_MODE:      storm_reg      = value;
            default: ;
        endcase
    endtask

    task automatic queue_pixel(logic [7:0] red, logic [7:0] green, logic [7:0] blue,
                               logic [4:0] step, logic last);
        t_pixel_in px;
        px.pixel_red    = red;
        px.pixel_green  = green;
        px.pixel_blue   = blue;
        px.damping_step = step;
        px.row_last     = last;
        pixel_backlog.push_back(px);
        queued_count++;
    endtask

    // Every request yields one result, so idle means all requests answered
    task automatic wait_idle();
        do @(posedge i_clk); while (checked_count != queued_count);
    endtask

    // Queue one row: mostly darkening ramps that build long smear runs,
    // plus noise rows and stray pixels; leave the row open if close_row is 0
    task automatic queue_row(bit close_row);
        int unsigned len;
        int unsigned shape;
        int unsigned k;
        int unsigned lvl;
        logic [7:0]  base_r;
        logic [7:0]  base_g;
        logic [7:0]  base_b;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [4:0]  step;
        len    = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 48);
        shape  = $urandom_range(0, 3);
        lvl    = $urandom_range(96, 255);
        base_r = (shape == 1) ? 8'd255 : 8'($urandom);
        base_g = (shape == 1) ? 8'd255 : 8'($urandom);
        base_b = (shape == 1) ? 8'd255 : 8'($urandom);
        for (k = 0; k < len; k++) begin
            step = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                               : 5'($urandom_range(3, 25));
            if (shape == 0 || $urandom_range(0, 11) == 0) begin
                red   = 8'($urandom_range(0, 255));
                green = 8'($urandom_range(0, 255));
                blue  = 8'($urandom_range(0, 255));
            end else begin
                red   = 8'((base_r * lvl) >> 8);
                green = 8'((base_g * lvl) >> 8);
                blue  = 8'((base_b * lvl) >> 8);
            end
            queue_pixel(red, green, blue, step, close_row && (k == len - 1));
            // darken by a small step; flare back up now and then
            if ((shape == 3 && $urandom_range(0, 5) == 0) || lvl <= 8)
                lvl = $urandom_range(160, 255);
            else
                lvl = lvl - $urandom_range(0, 8);
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int unsigned phase_idx;
        int unsigned half;
        int unsigned target;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows under wind, left to right
        write_register(CFG_BLOW_FROM_RIGHT, 1'b0);
        write_register(CFG_STORM_MODE, 1'b0);
        // white source, then black and each pure primary smeared toward it
        queue_pixel(8'd255, 8'd255, 8'd255, 5'd3,  1'b0);
        queue_pixel(8'd0,   8'd0,   8'd0,   5'd25, 1'b0);
        queue_pixel(8'd0,   8'd0,   8'd0,   5'd3,  1'b0);
        queue_pixel(8'd255, 8'd0,   8'd0,   5'd31, 1'b0);
        queue_pixel(8'd0,   8'd255, 8'd0,   5'd0,  1'b0);
        queue_pixel(8'd0,   8'd0,   8'd255, 5'd25, 1'b0);
        // last pixel of a row passes even though darker
        queue_pixel(8'd128, 8'd128, 8'd128, 5'd3,  1'b1);
        // row of a single pixel: row start and row end at once
        queue_pixel(8'd17,  8'd34,  8'd51,  5'd5,  1'b1);
        // zero damping: the counter never falls
        queue_pixel(8'd200, 8'd200, 8'd200, 5'd0,  1'b0);
        queue_pixel(8'd100, 8'd100, 8'd100, 5'd9,  1'b0);
        queue_pixel(8'd50,  8'd50,  8'd50,  5'd31, 1'b0);
        queue_pixel(8'd10,  8'd10,  8'd10,  5'd3,  1'b1);
        // equal luma is not darker: the second black becomes the source
        queue_pixel(8'd0,   8'd0,   8'd0,   5'd0,  1'b0);
        queue_pixel(8'd0,   8'd0,   8'd0,   5'd31, 1'b0);
        queue_pixel(8'd255, 8'd255, 8'd255, 5'd3,  1'b1);
        // counter runs out after four blends, the next darker pixel takes over
        queue_pixel(8'd250, 8'd250, 8'd250, 5'd25, 1'b0);
        queue_pixel(8'd240, 8'd240, 8'd240, 5'd3,  1'b0);
        queue_pixel(8'd230, 8'd230, 8'd230, 5'd3,  1'b0);
        queue_pixel(8'd220, 8'd220, 8'd220, 5'd3,  1'b0);
        queue_pixel(8'd210, 8'd210, 8'd210, 5'd3,  1'b0);
        queue_pixel(8'd200, 8'd200, 8'd200, 5'd3,  1'b0);
        queue_pixel(8'd190, 8'd190, 8'd190, 5'd3,  1'b0);
        queue_pixel(8'd0,   8'd0,   8'd0,   5'd3,  1'b1);
        wait_idle();

        // Random rows: the four corner settings first, then random settings
        for (phase_idx = 0; phase_idx < PHASES; phase_idx++) begin
            write_register(CFG_BLOW_FROM_RIGHT,
                           (phase_idx < 4) ? phase_idx[0] : 1'($urandom_range(0, 1)));
            write_register(CFG_STORM_MODE,
                           (phase_idx < 4) ? phase_idx[1] : 1'($urandom_range(0, 1)));
            for (half = 0; half < 2; half++) begin
                target = queued_count + PHASE_ITEMS / 2;
                while (queued_count < target) queue_row(1'b1);
                // hold off the sender until every result is back
                if (half == 0) wait_idle();
            end
            // now and then keep a source held across the register change
            if ($urandom_range(0, 1) == 1) queue_row(1'b0);
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (smeared_expected.size() != 0)
            report_mismatch("requests left without result", smeared_expected.size(), 0);
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Drop the run if it hangs well past the slowest legal schedule
    initial begin : watchdog
        #8_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
